FILE: hw/rtl/ytr_pkg.sv
// ytr_pkg: shared types, constants and helper functions for the YUYV to RGB converter.
// Used by ytr_pixel and yuyv_to_rgb_converter. Has no dependencies of its own.
package ytr_pkg;

  // Field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned COEF_W = 18;                 // signed, covers 113538
  localparam int unsigned DIFF_W = PIX_W + 1;          // signed chroma minus 128
  localparam int unsigned SUM_W  = COEF_W + DIFF_W;    // products and sums
  localparam int unsigned INT_W  = SUM_W - FRAC_W;     // floored integer part

  // Color matrix coefficients, 16 fraction bits, rounded to nearest
  localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd89831;
  localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd45744;
  localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22127;
  localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd113538;

  localparam logic [DIFF_W-1:0] CHROMA_OFS = 9'd128;
  localparam logic [PIX_W-1:0]  OUT_SCALE  = 8'd220;   // applied as (c * 220) >> 8
  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
  localparam logic [PIX_W-1:0]  OUT_MAX    = 8'd219;

  // One YUYV macropixel
  typedef struct packed {
    logic [PIX_W-1:0] first_luma;
    logic [PIX_W-1:0] blue_diff;
    logic [PIX_W-1:0] second_luma;
    logic [PIX_W-1:0] red_diff;
    logic             frame_end;
  } ytr_in_t;

  // Two RGB pixels
  typedef struct packed {
    logic [PIX_W-1:0] first_red;
    logic [PIX_W-1:0] first_green;
    logic [PIX_W-1:0] first_blue;
    logic [PIX_W-1:0] second_red;
    logic [PIX_W-1:0] second_green;
    logic [PIX_W-1:0] second_blue;
    logic             frame_end_out;
  } ytr_out_t;

  // Chroma products shared by both pixels of a macropixel
  typedef struct packed {
    logic signed [SUM_W-1:0] rv;
    logic signed [SUM_W-1:0] gv;
    logic signed [SUM_W-1:0] gu;
    logic signed [SUM_W-1:0] bu;
  } ytr_chroma_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } ytr_rgb_t;

  // Stage load enables handed to the per-pixel datapath
  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } ytr_ctrl_t;

  // Floor to integer, clamp to 0..255, scale by 220/256 with floor
  function automatic logic [PIX_W-1:0] clamp_scale(logic signed [SUM_W-1:0] sum);
    logic signed [INT_W-1:0] whole;
    logic [PIX_W-1:0]        clamped;
    logic [2*PIX_W-1:0]      scaled;
    whole = sum[SUM_W-1:FRAC_W];   // arithmetic floor: drop fraction bits
    if (whole[INT_W-1]) begin
      clamped = '0;
    end else if (whole > $signed({{(INT_W-PIX_W){1'b0}}, PIX_MAX})) begin
      clamped = PIX_MAX;
    end else begin
      clamped = whole[PIX_W-1:0];
    end
    scaled = clamped * OUT_SCALE;
    return scaled[2*PIX_W-1:PIX_W];
  endfunction

endpackage

FILE: hw/rtl/ytr_pixel.sv
// ytr_pixel: stages two and three of the converter for one pixel (sums, then clamp and scale).
// Depends on ytr_pkg.
module ytr_pixel import ytr_pkg::*; (
  input  logic             clk_i,
  input  ytr_ctrl_t        ctrl_i,
  input  logic [PIX_W-1:0] luma_i,
  input  ytr_chroma_t      chroma_i,
  output ytr_rgb_t         rgb_o
);

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] r_sum_d, g_sum_d, b_sum_d;
  logic signed [SUM_W-1:0] r_sum_q, g_sum_q, b_sum_q;
  ytr_rgb_t                rgb_d, rgb_q;

  // Stage 2: luma at 16 fraction bits combined with the chroma terms
  assign base    = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, luma_i, {FRAC_W{1'b0}}});
  assign r_sum_d = base + chroma_i.rv;
  assign g_sum_d = base - chroma_i.gv - chroma_i.gu;
  assign b_sum_d = base + chroma_i.bu;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      r_sum_q <= r_sum_d;
      g_sum_q <= g_sum_d;
      b_sum_q <= b_sum_d;
    end
  end

  // Stage 3: floor, clamp and scale each channel
  always_comb begin
    rgb_d.red   = clamp_scale(r_sum_q);
    rgb_d.green = clamp_scale(g_sum_q);
    rgb_d.blue  = clamp_scale(b_sum_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3_load) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

FILE: hw/rtl/yuyv_to_rgb_converter.sv
// yuyv_to_rgb_converter: top level, YUYV 4:2:2 macropixel in, two scaled RGB pixels out.
// Depends on ytr_pkg and ytr_pixel.

// Converts one YUYV macropixel per transaction into two RGB888 pixels whose channels are
// scaled by 220/256 (range 0..219); the end-of-frame flag travels with its macropixel.
// The datapath is a three-stage pipeline: chroma products, luma sums, then clamp and
// scale into the output register. An accepted transaction moves through the stage-one
// registers, the sum registers and the output register in that order, and any stage
// holds while the one after it is full and cannot move. One transaction is taken every
// cycle as long as the output side keeps out_ready_i high. in_ready_o only drops when
// all three stages hold data and the output is stalled.
module yuyv_to_rgb_converter import ytr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ytr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ytr_out_t out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  ytr_ctrl_t ctrl;

  logic signed [DIFF_W-1:0] du, dv;
  ytr_chroma_t              chroma_d, chroma_q;
  logic [PIX_W-1:0]         y0_q, y1_q;
  logic                     fe1_q, fe2_q, fe3_q;
  ytr_rgb_t                 rgb0, rgb1;

  // Stage enables: a stage may load when it is empty or the next one moves
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign ctrl.s2_load = en2 && v1_q;
  assign ctrl.s3_load = en3 && v2_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: chroma offsets and the four shared products
  assign du = $signed({1'b0, in_data_i.blue_diff} - CHROMA_OFS);
  assign dv = $signed({1'b0, in_data_i.red_diff} - CHROMA_OFS);

  always_comb begin
    chroma_d.rv = COEF_RV * dv;
    chroma_d.gv = COEF_GV * dv;
    chroma_d.gu = COEF_GU * du;
    chroma_d.bu = COEF_BU * du;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      chroma_q <= chroma_d;
      y0_q     <= in_data_i.first_luma;
      y1_q     <= in_data_i.second_luma;
      fe1_q    <= in_data_i.frame_end;
    end
    if (ctrl.s2_load) fe2_q <= fe1_q;
    if (ctrl.s3_load) fe3_q <= fe2_q;
  end

  // Stages 2 and 3, one instance per pixel
  ytr_pixel u_pix0 (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .luma_i   (y0_q),
    .chroma_i (chroma_q),
    .rgb_o    (rgb0)
  );

  ytr_pixel u_pix1 (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .luma_i   (y1_q),
    .chroma_i (chroma_q),
    .rgb_o    (rgb1)
  );

  assign out_valid_o = v3_q;

  always_comb begin
    out_data_o.first_red     = rgb0.red;
    out_data_o.first_green   = rgb0.green;
    out_data_o.first_blue    = rgb0.blue;
    out_data_o.second_red    = rgb1.red;
    out_data_o.second_green  = rgb1.green;
    out_data_o.second_blue   = rgb1.blue;
    out_data_o.frame_end_out = fe3_q;
  end

  // Back-pressure only when every stage is occupied and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("in_ready_o low with a free pipeline slot");

  // A new result only arrives from stage two
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && !out_ready_i)) |-> $past(v2_q))
    else $error("output valid without data in stage two");

  // Scaled channels stay within 0..219
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.first_red <= OUT_MAX && out_data_o.first_green <= OUT_MAX
      && out_data_o.first_blue <= OUT_MAX && out_data_o.second_red <= OUT_MAX
      && out_data_o.second_green <= OUT_MAX && out_data_o.second_blue <= OUT_MAX))
    else $error("output channel above scaled range");

endmodule
